### rtl/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and the quarter-wave sine table for the RGB LED
// effect controller.
// ----------------------------------------------------------------------------
package rgbled_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int SINE_ENTRIES = 64;

  localparam int LEVEL_W   = 8;
  localparam int STEP_W    = 16;
  localparam int SINE_W    = 15;
  localparam int U_W       = SINE_W + 1;
  localparam int PROD_W    = U_W + LEVEL_W;
  localparam int OFS_W     = $clog2(SINE_ENTRIES);
  localparam int POS_W     = OFS_W + 2;
  localparam int ROM_AW    = $clog2(SINE_ENTRIES + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam longint unsigned Q15_MAX    = 64'd32767;
  localparam longint unsigned LEVEL_DIV  = 2 * Q15_MAX;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Channel phase offsets of one third and two thirds of a turn
  localparam longint unsigned PHASE_OFF_G = ((64'd1 << PHASE_BITS) + 64'd1) / 3;
  localparam longint unsigned PHASE_OFF_B = ((64'd2 << PHASE_BITS) + 64'd1) / 3;

  localparam logic [LEVEL_W-1:0] PEAK_RESET = LEVEL_W'(50);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(522);

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_STEADY = 2'd1,
    MODE_BLINK  = 2'd2,
    MODE_CYCLE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_LEVEL = 1'b0,
    REG_PHASE_STEP = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } rgb_t;

  // Q15 sine of k * pi / (2 * SINE_ENTRIES), Q30 Taylor series, rounded
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    int unsigned i;
    x    = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum * Q15_MAX + (64'd1 << 29)) >> 30;
    if (q > Q15_MAX) begin
      q = Q15_MAX;
    end
    return q[SINE_W-1:0];
  endfunction

  localparam int SINE_TBL_W = (SINE_ENTRIES + 1) * SINE_W;

  function automatic logic [SINE_TBL_W-1:0] build_sine_table();
    logic [SINE_TBL_W-1:0] tbl;
    int unsigned k;
    tbl = '0;
    for (k = 0; k <= SINE_ENTRIES; k++) begin
      tbl[k*SINE_W +: SINE_W] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam logic [SINE_TBL_W-1:0] SINE_TABLE = build_sine_table();

  // floor((s + 32767) * peak / 65534) for the sine of one phase
  function automatic logic [LEVEL_W-1:0] channel_level(input logic [PHASE_BITS-1:0] ph,
                                                       input logic [LEVEL_W-1:0]    peak);
    logic [POS_W-1:0]  pos;
    logic [1:0]        quad;
    logic [OFS_W-1:0]  ofs;
    logic [ROM_AW-1:0] idx;
    logic [SINE_W-1:0] mag;
    logic [U_W-1:0]    u;
    logic [PROD_W-1:0] prod;
    logic [LEVEL_W-1:0] q0;
    logic [U_W:0]      rem;
    pos  = ph[PHASE_BITS-1 -: POS_W];
    quad = pos[POS_W-1 -: 2];
    ofs  = pos[OFS_W-1:0];
    idx  = quad[0] ? (ROM_AW'(SINE_ENTRIES) - ROM_AW'(ofs)) : ROM_AW'(ofs);
    mag  = SINE_TABLE[idx*SINE_W +: SINE_W];
    u    = quad[1] ? (U_W'(Q15_MAX) - U_W'(mag)) : (U_W'(Q15_MAX) + U_W'(mag));
    prod = PROD_W'(u) * PROD_W'(peak);
    // Divide by 2^U_W first, then correct by one: the divisor is 2^U_W - 2
    q0   = prod[PROD_W-1:U_W];
    rem  = (U_W+1)'(prod[U_W-1:0]) + (U_W+1)'({q0, 1'b0});
    return (rem >= (U_W+1)'(LEVEL_DIV)) ? LEVEL_W'(q0 + 1'b1) : q0;
  endfunction

endpackage

### rtl/rgb_led_effect_controller_core.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_controller_core
// RGB LED effect engine: off, steady, blink and sine colour cycle.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the master side takes results; the
//   path between the input stage and the result register on the master
//   side is the sine lookup and one 16x8 multiply per channel.
// Reset: mode colour cycle, phase 0, red off, peak_level 50, phase_step 522;
//   both stages empty.
module rgb_led_effect_controller_core
  import rgbled_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // Slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [1:0] new_mode, [7:2] zero
  input  logic                 s_axis_tuser,  // [0] operation
  // Master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  // Block state
  logic [LEVEL_W-1:0]    peak_q;
  logic [STEP_W-1:0]     step_q;
  mode_e                 mode_q, mode_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic                  red_on_q, red_on_d;

  // Input stage
  logic  s1_valid_q;
  op_e   s1_op_q;
  mode_e s1_mode_q;
  logic  s1_adv;

  // Result stage
  logic  out_valid_q;
  rgb_t  out_data_q;

  // Result of the item held in the input stage
  logic                  res_valid;
  rgb_t                  res_data;
  logic [PHASE_BITS-1:0] base_phase;
  rgb_t                  cycle_rgb;

  // --------------------------------------------------------------------------
  // Configuration: always ready, writes land directly in the registers
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= PEAK_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PEAK_LEVEL: peak_q <= cfg_data_i[LEVEL_W-1:0];
        REG_PHASE_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the input stage advances whenever the result register is
  // empty or being drained, so only a stalled result blocks the next item
  // --------------------------------------------------------------------------
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Payload of the input stage: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op_q   <= op_e'(s_axis_tuser);
      s1_mode_q <= mode_e'(s_axis_tdata[1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Colour cycle: a mode set starts from phase zero, a tick from the
  // accumulator. Green and blue sit a third and two thirds of a turn ahead.
  // --------------------------------------------------------------------------
  assign base_phase = (s1_op_q == OP_SET) ? '0 : phase_q;

  always_comb begin
    cycle_rgb.red   = channel_level(base_phase, peak_q);
    cycle_rgb.green = channel_level(base_phase + PHASE_BITS'(PHASE_OFF_G), peak_q);
    cycle_rgb.blue  = channel_level(base_phase + PHASE_BITS'(PHASE_OFF_B), peak_q);
  end

  // --------------------------------------------------------------------------
  // Mode handling and next state
  // --------------------------------------------------------------------------
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    red_on_d  = red_on_q;
    res_valid = 1'b0;
    res_data  = '0;
    unique case (s1_op_q)
      OP_SET: begin
        mode_d = s1_mode_q;
        unique case (s1_mode_q)
          MODE_OFF: begin
            res_valid = 1'b1;
          end
          MODE_STEADY: begin
            res_valid      = 1'b1;
            res_data.red   = peak_q;
            res_data.green = peak_q;
            res_data.blue  = peak_q;
          end
          MODE_BLINK: begin
            // Restart blinking dark; nothing to show yet
            red_on_d = 1'b0;
          end
          MODE_CYCLE: begin
            res_valid = 1'b1;
            res_data  = cycle_rgb;
            phase_d   = PHASE_BITS'(step_q);
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        unique case (mode_q)
          MODE_BLINK: begin
            red_on_d     = !red_on_q;
            res_valid    = 1'b1;
            res_data.red = red_on_q ? '0 : peak_q;
          end
          MODE_CYCLE: begin
            res_valid = 1'b1;
            res_data  = cycle_rgb;
            phase_d   = phase_q + PHASE_BITS'(step_q);
          end
          default: ;  // off and steady ignore ticks
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CYCLE;
      phase_q  <= '0;
      red_on_q <= 1'b0;
    end else if (s1_adv) begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      red_on_q <= red_on_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on advance, drop once the transfer completes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  // A colour-cycle set restarts the accumulator at one step past zero
  a_cycle_set_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_op_q == OP_SET && s1_mode_q == MODE_CYCLE
    |=> phase_q == PHASE_BITS'($past(step_q)))
    else $error("phase not restarted on colour-cycle set");

  // An item without a result leaves the result register empty
  a_no_result_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !res_valid |=> !out_valid_q)
    else $error("result shown for an item that has none");

  // Steady shows the same level on all channels
  a_steady_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_op_q == OP_SET && s1_mode_q == MODE_STEADY
    |=> out_valid_q && m_axis_tdata[7:0] == m_axis_tdata[15:8]
        && m_axis_tdata[7:0] == m_axis_tdata[23:16])
    else $error("steady levels differ");

  // A stalled input stage keeps its item
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_op_q) && $stable(s1_mode_q))
    else $error("input stage lost a stalled item");
`endif

endmodule

### tb/rgb_led_effect_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_effect_checker
// Watches the configuration, slave and master channels of the RGB LED effect
// controller, keeps its own model of mode, phase and blink state, predicts
// the colour of each input transfer that has one and compares the results in order.
// ----------------------------------------------------------------------------
module rgb_led_effect_checker
  import rgbled_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [7:0]           s_tdata_i,   // [1:0] new_mode, [7:2] zero
  input  logic                 s_tuser_i,   // [0] operation
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [23:0]          m_tdata_i,   // [7:0] red, [15:8] green, [23:16] blue
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [15:0]     GREEN_SHIFT      = 16'd21845;
  localparam logic [15:0]     BLUE_SHIFT       = 16'd43691;
  localparam int              MAX_PRINTED      = 30;

  logic [14:0] quarter_sine [0:SINE_ENTRIES];

  mode_e       led_mode;
  logic [15:0] cycle_phase;
  logic        red_lit;
  logic [7:0]  peak;
  logic [15:0] step;
  rgb_t        colour_q[$];
  int          mismatches;
  int          checked;

  // Q15 sine of k quarter-table steps, Q30 Taylor series with rounding
  function automatic logic [14:0] q15_sine(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned q;
    int unsigned     n;
    ang  = (64'(k) * QUARTER_TURN_Q30) / 64'(SINE_ENTRIES);
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (n = 1; n <= 7; n++) begin
      term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    q = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return (q > 64'd32767) ? 15'd32767 : 15'(q);
  endfunction

  initial begin
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      quarter_sine[k] = q15_sine(k);
    end
  end

  // floor((sin + 1) / 2 * peak) with the sine mirrored out of a quarter wave
  function automatic logic [7:0] led_level(input logic [15:0] ph, input logic [7:0] pk);
    logic [7:0]  pos;
    logic [5:0]  ofs;
    logic [14:0] mag;
    int unsigned u;
    pos = ph[15:8];
    ofs = pos[5:0];
    mag = pos[6] ? quarter_sine[SINE_ENTRIES - ofs] : quarter_sine[ofs];
    u   = pos[7] ? (32767 - mag) : (32767 + mag);
    return 8'((u * pk) / 65534);
  endfunction

  task automatic push_cycle_colour();
    rgb_t c;
    c.red   = led_level(cycle_phase, peak);
    c.green = led_level(cycle_phase + GREEN_SHIFT, peak);
    c.blue  = led_level(cycle_phase + BLUE_SHIFT, peak);
    colour_q.push_back(c);
    cycle_phase = cycle_phase + step;
  endtask

  task automatic apply_item(input op_e op, input mode_e mode);
    rgb_t c;
    c = '0;
    if (op == OP_SET) begin
      led_mode = mode;
      case (mode)
        MODE_OFF: begin
          colour_q.push_back(c);
        end
        MODE_STEADY: begin
          c.red   = peak;
          c.green = peak;
          c.blue  = peak;
          colour_q.push_back(c);
        end
        MODE_BLINK: begin
          red_lit = 1'b0;
        end
        default: begin
          cycle_phase = '0;
          push_cycle_colour();
        end
      endcase
    end else begin
      case (led_mode)
        MODE_BLINK: begin
          red_lit = ~red_lit;
          c.red   = red_lit ? peak : 8'd0;
          colour_q.push_back(c);
        end
        MODE_CYCLE: begin
          push_cycle_colour();
        end
        default: ;  // off and steady ignore ticks
      endcase
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_colour(input rgb_t got);
    rgb_t want;
    if (colour_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                got.red, got.green, got.blue));
      return;
    end
    want = colour_q.pop_front();
    checked++;
    if (got.red != want.red) begin
      report_mismatch($sformatf("red %0d, predicted %0d", got.red, want.red));
    end
    if (got.green != want.green) begin
      report_mismatch($sformatf("green %0d, predicted %0d", got.green, want.green));
    end
    if (got.blue != want.blue) begin
      report_mismatch($sformatf("blue %0d, predicted %0d", got.blue, want.blue));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      led_mode    = MODE_CYCLE;
      cycle_phase = '0;
      red_lit     = 1'b0;
      peak        = PEAK_RESET;
      step        = STEP_RESET;
      colour_q.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PEAK_LEVEL: peak = cfg_data_i[7:0];
          REG_PHASE_STEP: step = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_item(op_e'(s_tuser_i), mode_e'(s_tdata_i[1:0]));
      end
      if (m_tvalid_i && m_tready_i) begin
        check_colour(rgb_t'(m_tdata_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= colour_q.size();
    checked_o        <= checked;
  end

endmodule

### tb/rgb_led_effect_controller_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_led_effect_controller_core_tb
// Drives mode changes and ticks into the RGB LED effect controller under
// several peak/step settings and handshake patterns; a checker beside the
// block predicts every colour and counts mismatches.
// ----------------------------------------------------------------------------
module rgb_led_effect_controller_core_tb;
  import rgbled_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int PHASE_ITEMS  = 200;
  localparam int SETTLE_TICKS = 6;     // covers the two-stage pipeline

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [1:0] new_mode, [7:2] zero
  logic                 s_axis_tuser  = 1'b0; // [0] operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue

  int mismatches;
  int pending;
  int checked;

  // Handshake shaping, changed per phase by the stimulus
  int tx_gap_pct      = 0;
  int rx_stall_pct    = 0;
  int rx_hold_request = 0;

  // Stimulus bookkeeping
  mode_e sent_mode = MODE_CYCLE;  // mode as last set, to spot ignored ticks
  int    sent      = 0;
  int    effective = 0;           // transfers the block does not just ignore

  rgb_led_effect_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rgb_led_effect_checker colour_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request > 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no channel has transferred for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("rgb_led_effect_controller_core_tb NOT OK");
    $finish;
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until
  // the slave side takes it.
  task automatic send_item(input op_e op, input mode_e mode);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, mode};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    if (op == OP_SET || sent_mode == MODE_BLINK || sent_mode == MODE_CYCLE) begin
      effective++;
    end
    if (op == OP_SET) begin
      sent_mode = mode;
    end
  endtask

  // Mostly ticks, with mode changes leaning towards the animated modes
  task automatic send_random_item();
    int    pick;
    mode_e mode;
    pick = $urandom_range(9);
    case (pick)
      0:       mode = MODE_OFF;
      1:       mode = MODE_STEADY;
      2, 3, 4: mode = MODE_BLINK;
      default: mode = MODE_CYCLE;
    endcase
    if ($urandom_range(99) < 78) begin
      send_item(OP_TICK, mode_e'($urandom_range(3)));
    end else begin
      send_item(OP_SET, mode);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = effective + count;
    while (effective < target) send_random_item();
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Peak only uses the low byte: put noise in the upper byte
  task automatic set_peak(input logic [7:0] level);
    write_reg(REG_PEAK_LEVEL, {8'($urandom_range(255)), level});
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, colour cycle out of reset, every mode,
    // ignored ticks in off and steady, blink toggling and re-entry.
    send_item(OP_TICK, MODE_CYCLE);
    send_item(OP_TICK, MODE_OFF);
    send_item(OP_SET,  MODE_CYCLE);
    send_item(OP_TICK, MODE_BLINK);
    send_item(OP_SET,  MODE_OFF);
    send_item(OP_TICK, MODE_STEADY);
    send_item(OP_SET,  MODE_STEADY);
    send_item(OP_TICK, MODE_BLINK);
    send_item(OP_SET,  MODE_BLINK);
    send_item(OP_TICK, MODE_OFF);
    send_item(OP_TICK, MODE_CYCLE);
    send_item(OP_TICK, MODE_STEADY);
    send_item(OP_SET,  MODE_BLINK);
    send_item(OP_TICK, MODE_BLINK);
    send_item(OP_SET,  MODE_OFF);
    send_item(OP_SET,  MODE_CYCLE);
    send_item(OP_TICK, MODE_OFF);
    send_item(OP_TICK, MODE_OFF);

    // Full peak and a quarter turn per tick: hit every quadrant boundary
    set_peak(8'd255);
    write_reg(REG_PHASE_STEP, 16'd16384);
    send_item(OP_SET, MODE_CYCLE);
    repeat (4) send_item(OP_TICK, MODE_CYCLE);
    send_item(OP_SET, MODE_STEADY);

    // Zero peak: everything dark
    set_peak(8'd0);
    send_item(OP_SET, MODE_STEADY);
    send_item(OP_SET, MODE_CYCLE);

    // Smallest step, full peak, no idling
    set_peak(8'd255);
    write_reg(REG_PHASE_STEP, 16'd1);
    run_random(PHASE_ITEMS);

    // Largest step (phase walks backwards), zero peak, sender mostly idle
    set_peak(8'd0);
    write_reg(REG_PHASE_STEP, 16'hFFFF);
    tx_gap_pct = 81;
    run_random(PHASE_ITEMS);

    // Random settings, receiver stalling most of the time
    set_peak(8'($urandom_range(1, 254)));
    write_reg(REG_PHASE_STEP, 16'($urandom_range(65535)));
    tx_gap_pct   = 0;
    rx_stall_pct = 81;
    run_random(PHASE_ITEMS);

    // Full peak, random step, light idling on both sides
    set_peak(8'd255);
    write_reg(REG_PHASE_STEP, 16'($urandom_range(65535)));
    tx_gap_pct   = 6;
    rx_stall_pct = 6;
    run_random(PHASE_ITEMS);

    // Back-pressure: hold the result side off while ticks keep coming,
    // so the block fills up and stalls its slave side
    set_peak(8'($urandom_range(255)));
    write_reg(REG_PHASE_STEP, 16'($urandom_range(65535)));
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    send_item(OP_SET, MODE_CYCLE);
    rx_hold_request = HOLD_CYCLES;
    repeat (40) send_item(OP_TICK, MODE_CYCLE);
    run_random(PHASE_ITEMS - 40);

    // Frozen colour: zero step at the reset peak
    set_peak(8'd50);
    write_reg(REG_PHASE_STEP, 16'd0);
    run_random(40);

    settle();
    $display("Covered %0d input transfers (%0d not ignored), %0d colours checked,",
             sent, effective, checked);
    $display("over nine peak/step settings, four idling patterns and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("rgb_led_effect_controller_core_tb OK");
    end else begin
      $display("rgb_led_effect_controller_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/rgbled_pkg.sv
rtl/rgb_led_effect_controller_core.sv
tb/rgb_led_effect_checker.sv
tb/rgb_led_effect_controller_core_tb.sv
